FILE: design/four_level_page_table_updater_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page table updater
// Shared assertion wrappers; defining ASSERT_OFF removes them all.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_UPDATER_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_UPDATER_MACROS_SVH
`ifndef ASSERT_OFF
`define PTU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("page table updater assertion failed");
`define PTU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("page table updater assertion failed");
`else
`define PTU_ASSERT(lbl, clk, rst_n, prop)
`define PTU_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: design/ptu_pkg.sv
// ----------------------------------------------------------------------------
// ptu_pkg
// Sizes, codes and types shared by the page table updater modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ptu_pkg;
    // Pool size must be a power of two; foreign pointers wrap modulo the pool.
    localparam int TABLE_SLOTS       = 16;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int SLOT_W            = $clog2(TABLE_SLOTS);
    localparam int CNT_W             = $clog2(TABLE_SLOTS + 1);
    localparam int MEM_DEPTH         = TABLE_SLOTS * ENTRIES_PER_TABLE;
    localparam int MEM_AW            = SLOT_W + IDX_W;
    localparam int ENTRY_W           = 64;
    localparam int FRAME_W           = 40;
    localparam int PAGE_W            = 36;
    localparam int FLAG_W            = 12;
    localparam int CFG_AW            = 4;
    localparam int CFG_DW            = 64;

    localparam logic [CFG_AW-1:0] REG_TABLE_POOL_FRAME = 4'h0;
    localparam logic [FLAG_W-1:0] DIR_FLAGS = 12'h003;
    localparam logic REQ_MAP   = 1'b0;
    localparam logic REQ_UNMAP = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE       = 2'd0,
        STATUS_POOL_EMPTY = 2'd1,
        STATUS_NOT_MAPPED = 2'd2
    } t_status;
endpackage
`default_nettype wire

FILE: design/ptu_ram.sv
// ----------------------------------------------------------------------------
// ptu_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ptu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

FILE: design/ptu_cfg.sv
// ----------------------------------------------------------------------------
// ptu_cfg
// APB register block holding the table pool base frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ptu_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ptu_pkg::CFG_AW-1:0]    paddr,
    input  wire logic [ptu_pkg::CFG_DW-1:0]    pwdata,
    output logic      [ptu_pkg::CFG_DW-1:0]    prdata,
    output logic                               pready,
    output logic      [ptu_pkg::FRAME_W-1:0]   o_pool_frame
);
    logic [ptu_pkg::FRAME_W-1:0] r_pool_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_frame <= '0;
        end else if (psel && penable && pwrite
                     && paddr == ptu_pkg::REG_TABLE_POOL_FRAME) begin
            r_pool_frame <= pwdata[ptu_pkg::FRAME_W-1:0];
        end
    end

    assign pready       = 1'b1;
    assign prdata       = (paddr == ptu_pkg::REG_TABLE_POOL_FRAME)
                          ? ptu_pkg::CFG_DW'(r_pool_frame) : '0;
    assign o_pool_frame = r_pool_frame;
endmodule
`default_nettype wire

FILE: design/four_level_page_table_updater.sv
// ----------------------------------------------------------------------------
// four_level_page_table_updater
// Maps and unmaps 4 KiB pages in a four-level table kept in one table RAM.
// ----------------------------------------------------------------------------
//   channel   direction  handshake              word
//   request   in         i_valid / o_stall      type, page, frame, flags, xd
//   result    out        o_valid / i_stall      status, tables, flush, page
//   config    in         APB psel/penable       table pool base frame
//
// An unmap or a map through existing tables runs from acceptance to the result
// word as one read-evaluate pair per directory level through the registered
// RAM read, a leaf write and a result state. The next word is taken once the
// updater is back in idle. Each new table adds a clear of all 512 entries, one RAM write per entry.
// After reset the whole table RAM is cleared before the first word is taken.
// A stalled result blocks only the completion of the following request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "four_level_page_table_updater_macros.svh"
module four_level_page_table_updater (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic                              i_req_type,
    input  wire logic [ptu_pkg::PAGE_W-1:0]        i_virt_page,
    input  wire logic [ptu_pkg::FRAME_W-1:0]       i_phys_frame,
    input  wire logic [ptu_pkg::FLAG_W-1:0]        i_leaf_flags,
    input  wire logic                              i_exec_disable,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic      [1:0]                        o_status,
    output logic      [1:0]                        o_tables_created,
    output logic                                   o_flush_request,
    output logic      [ptu_pkg::PAGE_W-1:0]        o_flush_page,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ptu_pkg::CFG_AW-1:0]        paddr,
    input  wire logic [ptu_pkg::CFG_DW-1:0]        pwdata,
    output logic      [ptu_pkg::CFG_DW-1:0]        prdata,
    output logic                                   pready
);
    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_READ, S_EVAL, S_CLEAR, S_LEAF, S_DONE
    } t_state;

    t_state                          r_state;
    logic [1:0]                      r_level;
    logic [ptu_pkg::SLOT_W-1:0]      r_slot;
    logic [ptu_pkg::CNT_W-1:0]       r_next_free;
    logic [ptu_pkg::IDX_W-1:0]       r_cnt;
    logic [1:0]                      r_created;
    ptu_pkg::t_status                r_status;
    logic                            r_unmap;
    logic [ptu_pkg::PAGE_W-1:0]      r_vpage;
    logic [ptu_pkg::FRAME_W-1:0]     r_frame;
    logic [ptu_pkg::FLAG_W-1:0]      r_flags;
    logic                            r_xd;
    logic                            r_o_valid;
    logic [1:0]                      r_o_status;
    logic [1:0]                      r_o_created;
    logic                            r_o_flush;
    logic [ptu_pkg::PAGE_W-1:0]      r_o_page;

    logic [ptu_pkg::FRAME_W-1:0]     pool_frame;
    logic [ptu_pkg::IDX_W-1:0]       idx_cur;
    logic [ptu_pkg::ENTRY_W-1:0]     rd_data;
    logic [ptu_pkg::ENTRY_W-1:0]     entry;
    logic                            present;
    logic                            alloc_ok;
    logic [ptu_pkg::SLOT_W-1:0]      fresh;
    logic [ptu_pkg::SLOT_W-1:0]      next_slot;
    logic                            mem_wr_en;
    logic [ptu_pkg::MEM_AW-1:0]      mem_wr_addr;
    logic [ptu_pkg::ENTRY_W-1:0]     mem_wr_data;
    logic                            mem_rd_en;

    ptu_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_pool_frame (pool_frame)
    );

    ptu_ram #(
        .WIDTH (ptu_pkg::ENTRY_W),
        .DEPTH (ptu_pkg::MEM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr ({r_slot, idx_cur}),
        .o_rd_data (rd_data)
    );

    always_comb begin
        case (r_level)
            2'd3:    idx_cur = r_vpage[3*ptu_pkg::IDX_W +: ptu_pkg::IDX_W];
            2'd2:    idx_cur = r_vpage[2*ptu_pkg::IDX_W +: ptu_pkg::IDX_W];
            2'd1:    idx_cur = r_vpage[ptu_pkg::IDX_W +: ptu_pkg::IDX_W];
            default: idx_cur = r_vpage[ptu_pkg::IDX_W-1:0];
        endcase
    end

    assign entry     = rd_data;
    assign present   = entry[0];
    assign next_slot = entry[12 +: ptu_pkg::SLOT_W] - pool_frame[ptu_pkg::SLOT_W-1:0];
    assign alloc_ok  = r_next_free < ptu_pkg::CNT_W'(ptu_pkg::TABLE_SLOTS);
    assign fresh     = r_next_free[ptu_pkg::SLOT_W-1:0];
    assign mem_rd_en = (r_state == S_READ);

    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = {r_slot, idx_cur};
        mem_wr_data = '0;
        case (r_state)
            S_INIT: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = {r_slot, r_cnt};
            end
            S_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = {r_slot, r_cnt};
            end
            S_EVAL: begin
                mem_wr_en   = !present && r_unmap == ptu_pkg::REQ_MAP && alloc_ok;
                mem_wr_data = {12'b0, pool_frame + ptu_pkg::FRAME_W'(fresh),
                               ptu_pkg::DIR_FLAGS};
            end
            S_LEAF: begin
                mem_wr_en = 1'b1;
                if (r_unmap == ptu_pkg::REQ_MAP) begin
                    mem_wr_data = {r_xd, 11'b0, r_frame, r_flags};
                end
            end
            default: begin
                mem_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_slot      <= '0;
            r_next_free <= ptu_pkg::CNT_W'(1);
            r_o_valid   <= 1'b0;
        end else begin
            if (r_o_valid && !i_stall && r_state != S_DONE) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (&r_cnt) begin
                        r_slot <= r_slot + 1'b1;
                        if (&r_slot) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_unmap   <= i_req_type;
                        r_vpage   <= i_virt_page;
                        r_frame   <= i_phys_frame;
                        r_flags   <= i_leaf_flags;
                        r_xd      <= i_exec_disable;
                        r_level   <= 2'd3;
                        r_slot    <= '0;
                        r_created <= '0;
                        r_status  <= ptu_pkg::STATUS_DONE;
                        r_state   <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (present) begin
                        r_slot  <= next_slot;
                        r_level <= r_level - 1'b1;
                        r_state <= (r_level == 2'd1) ? S_LEAF : S_READ;
                    end else if (r_unmap == ptu_pkg::REQ_UNMAP) begin
                        r_status <= ptu_pkg::STATUS_NOT_MAPPED;
                        r_state  <= S_DONE;
                    end else if (!alloc_ok) begin
                        r_status <= ptu_pkg::STATUS_POOL_EMPTY;
                        r_state  <= S_DONE;
                    end else begin
                        r_slot      <= fresh;
                        r_next_free <= r_next_free + 1'b1;
                        r_created   <= r_created + 1'b1;
                        r_cnt       <= '0;
                        r_state     <= S_CLEAR;
                    end
                end
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (&r_cnt) begin
                        r_level <= r_level - 1'b1;
                        r_state <= (r_level == 2'd1) ? S_LEAF : S_READ;
                    end
                end
                S_LEAF: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid   <= 1'b1;
                        r_o_status  <= r_status;
                        r_o_created <= r_created;
                        r_o_flush   <= r_unmap && r_status == ptu_pkg::STATUS_DONE;
                        r_o_page    <= (r_unmap && r_status == ptu_pkg::STATUS_DONE)
                                       ? r_vpage : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_tables_created = r_o_created;
    assign o_flush_request  = r_o_flush;
    assign o_flush_page     = r_o_page;

    `PTU_ASSERT(a_pool_bound, i_clk, i_rst_n, r_next_free <= ptu_pkg::CNT_W'(ptu_pkg::TABLE_SLOTS))
    `PTU_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_valid && !o_stall) |=> o_stall)
    `PTU_ASSERT(a_flush_only_done, i_clk, i_rst_n, (o_valid && o_flush_request) |-> (o_status == ptu_pkg::STATUS_DONE && o_tables_created == 2'd0))
    `PTU_ASSERT_ALWAYS(a_reset_clears_valid, i_clk, !$past(i_rst_n) |-> !o_valid)
endmodule
`default_nettype wire
